// ===== rtl/u16t_pkg.sv =====
// ----------------------------------------------------------------------------
// u16t_pkg
// Shared types, constants and the UTF-8 encoder for the UTF-16LE transcoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u16t_pkg;

  localparam int unsigned FIFO_DEPTH_DEF = 4;

  localparam logic [5:0] HI_SURR_TAG = 6'b110110;  // 0xD800..0xDBFF
  localparam logic [5:0] LO_SURR_TAG = 6'b110111;  // 0xDC00..0xDFFF
  localparam logic [20:0] SUPP_BASE = 21'h10000;

  // Up to four UTF-8 bytes of one code point; len 0 means nothing to send.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      len;
  } enc_t;

  // One queued job: first code point, second code point, end-of-string mark.
  typedef struct packed {
    enc_t a;
    enc_t b;
    logic last;
  } job_t;

  typedef struct packed {
    logic push;
    job_t job;
  } front_out_t;

  function automatic enc_t encode_cp(logic [20:0] cp);
    enc_t e;
    e.bytes = '0;
    if (cp[20:7] == 14'd0) begin
      e.bytes[0] = {1'b0, cp[6:0]};
      e.len      = 3'd1;
    end else if (cp[20:11] == 10'd0) begin
      e.bytes[0] = {3'b110, cp[10:6]};
      e.bytes[1] = {2'b10, cp[5:0]};
      e.len      = 3'd2;
    end else if (cp[20:16] == 5'd0) begin
      e.bytes[0] = {4'b1110, cp[15:12]};
      e.bytes[1] = {2'b10, cp[11:6]};
      e.bytes[2] = {2'b10, cp[5:0]};
      e.len      = 3'd3;
    end else begin
      e.bytes[0] = {5'b11110, cp[20:18]};
      e.bytes[1] = {2'b10, cp[17:12]};
      e.bytes[2] = {2'b10, cp[11:6]};
      e.bytes[3] = {2'b10, cp[5:0]};
      e.len      = 3'd4;
    end
    return e;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/utf16le_to_utf8_transcoder.sv =====
// Path: the job for an accepted input byte is written into the queue when the
//   byte is accepted; the back then loads its UTF-8 bytes from the queue head
//   into the output register whenever the output register is free to take one.
// Throughput: one input byte per cycle while the job queue has room; the
//   output register drains one UTF-8 byte per cycle while out_stall is low.
// Reset: synchronous, active low; clears the unit pairing, surrogate and queue.
// ----------------------------------------------------------------------------
// utf16le_to_utf8_transcoder
// UTF-16LE byte stream in, UTF-8 byte stream out, with surrogate pairing.
// ----------------------------------------------------------------------------
`default_nettype none

module utf16le_to_utf8_transcoder
  import u16t_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_end_of_string,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            out_byte_valid,
  output logic            out_string_done
);

  front_out_t fo;
  job_t       head;
  logic       head_vld;
  logic       q_full;
  logic       pop;
  logic       accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  u16t_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .data_byte     (in_data_byte),
    .end_of_string (in_end_of_string),
    .fo            (fo)
  );

  u16t_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .fo        (fo),
    .pop       (pop),
    .head      (head),
    .not_empty (head_vld),
    .full      (q_full)
  );

  u16t_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .head_vld        (head_vld),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_byte_valid  (out_byte_valid),
    .out_string_done (out_string_done)
  );

endmodule

`default_nettype wire

// ===== rtl/u16t_front.sv =====
// ----------------------------------------------------------------------------
// u16t_front
// Pairs input bytes into code units, tracks surrogates and builds encode jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module u16t_front
  import u16t_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept,
  input  wire logic [7:0] data_byte,
  input  wire logic       end_of_string,
  output front_out_t      fo
);

  logic [7:0] held_low_r,  held_low_nxt;
  logic       second_r,    second_nxt;
  logic [9:0] pend_bits_r, pend_bits_nxt;
  logic       pend_vld_r,  pend_vld_nxt;

  logic [15:0] unit;
  logic [20:0] pend_cp;
  logic [20:0] pair_cp;
  enc_t        enc_a;
  enc_t        enc_b;
  enc_t        enc_none;

  assign unit     = {data_byte, held_low_r};
  assign pend_cp  = {5'd0, HI_SURR_TAG, pend_bits_r};
  assign pair_cp  = SUPP_BASE + {1'b0, pend_bits_r, unit[9:0]};
  assign enc_none = '0;

  always_comb begin
    held_low_nxt  = held_low_r;
    second_nxt    = second_r;
    pend_bits_nxt = pend_bits_r;
    pend_vld_nxt  = pend_vld_r;
    enc_a         = enc_none;
    enc_b         = enc_none;
    if (!second_r) begin
      held_low_nxt = data_byte;
      second_nxt   = 1'b1;
      // odd trailing byte: drop it, still flush a held surrogate
      if (end_of_string && pend_vld_r) begin
        enc_a = encode_cp(pend_cp);
      end
    end else begin
      second_nxt = 1'b0;
      if (pend_vld_r && unit[15:10] == LO_SURR_TAG) begin
        enc_a        = encode_cp(pair_cp);
        pend_vld_nxt = 1'b0;
      end else begin
        if (pend_vld_r) begin
          enc_a = encode_cp(pend_cp);
        end
        pend_vld_nxt = 1'b0;
        if (unit[15:10] == HI_SURR_TAG && !end_of_string) begin
          pend_bits_nxt = unit[9:0];
          pend_vld_nxt  = 1'b1;
        end else begin
          enc_b = encode_cp({5'd0, unit});
        end
      end
    end
    if (end_of_string) begin
      held_low_nxt  = '0;
      second_nxt    = 1'b0;
      pend_bits_nxt = '0;
      pend_vld_nxt  = 1'b0;
    end
  end

  always_comb begin
    fo.job.a    = enc_a;
    fo.job.b    = enc_b;
    fo.job.last = end_of_string;
    fo.push     = accept && (enc_a.len != 3'd0 || enc_b.len != 3'd0 || end_of_string);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_low_r  <= '0;
      second_r    <= 1'b0;
      pend_bits_r <= '0;
      pend_vld_r  <= 1'b0;
    end else if (accept) begin
      held_low_r  <= held_low_nxt;
      second_r    <= second_nxt;
      pend_bits_r <= pend_bits_nxt;
      pend_vld_r  <= pend_vld_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/u16t_fifo.sv =====
// ----------------------------------------------------------------------------
// u16t_fifo
// Short job queue between the classifying front and the byte-serial back.
// ----------------------------------------------------------------------------
`default_nettype none

module u16t_fifo
  import u16t_pkg::*;
#(
  parameter int unsigned DEPTH = FIFO_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire front_out_t fo,
  input  wire logic       pop,
  output job_t            head,
  output logic            not_empty,
  output logic            full
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  job_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]   count_r,  count_nxt;
  logic          do_push;
  logic          do_pop;

  assign not_empty = (count_r != '0);
  assign full      = (count_r == (AW+1)'(DEPTH));
  assign do_push   = fo.push && !full;
  assign do_pop    = pop && not_empty;
  assign head      = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= fo.job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/u16t_back.sv =====
// ----------------------------------------------------------------------------
// u16t_back
// Walks the head job one UTF-8 byte per cycle into the output register, unless out_stall holds it.
// ----------------------------------------------------------------------------
`default_nettype none

module u16t_back
  import u16t_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire job_t       head,
  input  wire logic       head_vld,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            out_byte_valid,
  output logic            out_string_done
);

  logic [2:0] idx_r, idx_nxt;
  logic       ovld_r, ovld_nxt;
  logic [7:0] obyte_r;
  logic       obv_r;
  logic       odone_r;

  logic [2:0] total;
  logic [2:0] last_idx;
  logic [2:0] b_idx;
  logic       load;
  logic       at_end;
  logic [7:0] sel_byte;

  assign total    = head.a.len + head.b.len;
  assign last_idx = (total == 3'd0) ? 3'd0 : total - 3'd1;
  assign b_idx    = idx_r - head.a.len;
  assign load     = head_vld && (!ovld_r || !out_stall);
  assign at_end   = (idx_r == last_idx);
  assign pop      = load && at_end;

  always_comb begin
    if (total == 3'd0) begin
      sel_byte = 8'd0;
    end else if (idx_r < head.a.len) begin
      sel_byte = head.a.bytes[idx_r[1:0]];
    end else begin
      sel_byte = head.b.bytes[b_idx[1:0]];
    end
  end

  always_comb begin
    idx_nxt  = idx_r;
    ovld_nxt = ovld_r;
    if (load) begin
      ovld_nxt = 1'b1;
      idx_nxt  = at_end ? 3'd0 : idx_r + 3'd1;
    end else if (!out_stall) begin
      ovld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      ovld_r <= 1'b0;
    end else begin
      idx_r  <= idx_nxt;
      ovld_r <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      obyte_r <= sel_byte;
      obv_r   <= (total != 3'd0);
      odone_r <= head.last && at_end;
    end
  end

  assign out_valid       = ovld_r;
  assign out_byte        = obyte_r;
  assign out_byte_valid  = obv_r;
  assign out_string_done = odone_r;

endmodule

`default_nettype wire

// ===== rtl/u16t_checker.sv =====
// ----------------------------------------------------------------------------
// u16t_checker
// Port-level checks on the transcoder output stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module u16t_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_byte,
  input wire logic       out_byte_valid,
  input wire logic       out_string_done
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // an empty result only ever marks the end of a string
  a_empty_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_string_done && out_byte == 8'd0)
    else $error("empty result without end mark");

  // a string cannot end on a multi-byte lead byte
  a_lead_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_valid && out_byte[7:6] == 2'b11 |-> !out_string_done)
    else $error("string ends on a lead byte");

  // reset empties the output register
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind utf16le_to_utf8_transcoder u16t_checker u_chk (.*);

`default_nettype wire

// ===== tb/utf8_output_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_output_checker
// Watches both channels of the UTF-16LE to UTF-8 transcoder, predicts the
// UTF-8 words each accepted input byte causes and compares them in order.
// ----------------------------------------------------------------------------

module utf8_output_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_string,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_byte,
  input  logic       out_byte_valid,
  input  logic       out_string_done,
  output int         mismatches,
  output int         words_owed,
  output int         bytes_in,
  output int         words_out,
  output int         strings_seen,
  output int         pairs_seen
);

  localparam logic [15:0] HIGH_FIRST = 16'hD800;
  localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
  localparam logic [15:0] LOW_FIRST  = 16'hDC00;
  localparam logic [15:0] LOW_LAST   = 16'hDFFF;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       done;
  } utf8_word_t;

  utf8_word_t utf8_q[$];

  // Decoder state mirrored from the block.
  logic [7:0] low_byte;
  logic       odd_phase;
  logic [9:0] high_bits;
  logic       high_held;

  initial begin
    mismatches   = 0;
    words_owed   = 0;
    bytes_in     = 0;
    words_out    = 0;
    strings_seen = 0;
    pairs_seen   = 0;
  end

  task automatic push_utf8(input logic [7:0] b);
    utf8_word_t w;
    w = '{data: b, valid: 1'b1, done: 1'b0};
    utf8_q.insert(utf8_q.size(), w);
  endtask

  task automatic encode_code_point(input logic [20:0] cp);
    if (cp < 21'h80) begin
      push_utf8(cp[7:0]);
    end else if (cp < 21'h800) begin
      push_utf8(8'hC0 | 8'(cp >> 6));
      push_utf8(8'h80 | 8'(cp & 21'h3F));
    end else if (cp < 21'h10000) begin
      push_utf8(8'hE0 | 8'(cp >> 12));
      push_utf8(8'h80 | 8'((cp >> 6) & 21'h3F));
      push_utf8(8'h80 | 8'(cp & 21'h3F));
    end else begin
      pairs_seen++;
      push_utf8(8'hF0 | 8'((cp >> 18) & 21'h07));
      push_utf8(8'h80 | 8'((cp >> 12) & 21'h3F));
      push_utf8(8'h80 | 8'((cp >> 6) & 21'h3F));
      push_utf8(8'h80 | 8'(cp & 21'h3F));
    end
  endtask

  task automatic flush_high();
    if (high_held) begin
      encode_code_point({5'd0, 6'b110110, high_bits});
      high_held = 1'b0;
      high_bits = '0;
    end
  endtask

  task automatic predict_utf8(input logic [7:0] b, input logic last);
    int         depth_before;
    logic [15:0] unit;
    utf8_word_t  marker;
    depth_before = utf8_q.size();
    if (!odd_phase) begin
      low_byte  = b;
      odd_phase = 1'b1;
    end else begin
      unit      = {b, low_byte};
      odd_phase = 1'b0;
      if (high_held && unit >= LOW_FIRST && unit <= LOW_LAST) begin
        encode_code_point(21'h10000 + {1'b0, high_bits, unit[9:0]});
        high_held = 1'b0;
        high_bits = '0;
      end else begin
        flush_high();
        // A high surrogate that ends the string is written on its own.
        if (unit >= HIGH_FIRST && unit <= HIGH_LAST && !last) begin
          high_bits = unit[9:0];
          high_held = 1'b1;
        end else begin
          encode_code_point({5'd0, unit});
        end
      end
    end
    if (last) begin
      flush_high();
      if (utf8_q.size() == depth_before) begin
        marker = '{data: 8'h00, valid: 1'b0, done: 1'b1};
        utf8_q.insert(utf8_q.size(), marker);
      end else begin
        utf8_q[utf8_q.size() - 1].done = 1'b1;
      end
      strings_seen++;
      low_byte  = '0;
      odd_phase = 1'b0;
      high_bits = '0;
      high_held = 1'b0;
    end
  endtask

  task automatic compare_utf8();
    utf8_word_t want;
    words_out++;
    if (utf8_q.size() == 0) begin
      $error("unexpected word: out_byte %0h, byte_valid %0b, string_done %0b",
             out_byte, out_byte_valid, out_string_done);
      mismatches++;
    end else begin
      want = utf8_q.pop_front();
      if (out_byte !== want.data) begin
        $error("out_byte: expected %0h, got %0h", want.data, out_byte);
        mismatches++;
      end
      if (out_byte_valid !== want.valid) begin
        $error("out_byte_valid: expected %0b, got %0b", want.valid, out_byte_valid);
        mismatches++;
      end
      if (out_string_done !== want.done) begin
        $error("out_string_done: expected %0b, got %0b", want.done, out_string_done);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      utf8_q.delete();
      low_byte  = '0;
      odd_phase = 1'b0;
      high_bits = '0;
      high_held = 1'b0;
    end else begin
      // Drain before predicting so the done mark lands on this input's words.
      if (out_valid && !out_stall)
        compare_utf8();
      if (in_valid && !in_stall) begin
        bytes_in++;
        predict_utf8(in_data_byte, in_end_of_string);
      end
    end
    words_owed = utf8_q.size();
  end

endmodule

// ===== tb/tb_utf16le_to_utf8_transcoder.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_utf16le_to_utf8_transcoder
// Drives UTF-16LE strings into the transcoder: directed corner strings, then
// random strings under changing idle and stall patterns, including a long
// output hold-off. A checker beside the block predicts and compares.
// ----------------------------------------------------------------------------

module tb_utf16le_to_utf8_transcoder;

  localparam int STALL_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 150;
  localparam int PHASE_BYTES  = 20;
  localparam int DRAIN_CYCLES = 10;

  logic       clk;
  logic       rst_n            = 1'b0;
  logic       in_valid         = 1'b0;
  logic       in_stall;
  logic [7:0] in_data_byte     = 8'h00;
  logic       in_end_of_string = 1'b0;
  logic       out_valid;
  logic       out_stall        = 1'b0;
  logic [7:0] out_byte;
  logic       out_byte_valid;
  logic       out_string_done;

  int mismatches, words_owed, bytes_in, words_out, strings_seen, pairs_seen;

  int idle_pct     = 0;
  int stall_pct    = 0;
  bit hold_request = 1'b0;
  int phase_sent;
  int quiet_cycles = 0;

  logic [15:0] unit_q[$];

  utf16le_to_utf8_transcoder i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_end_of_string (in_end_of_string),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_byte_valid   (out_byte_valid),
    .out_string_done  (out_string_done)
  );

  utf8_output_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_end_of_string (in_end_of_string),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_byte_valid   (out_byte_valid),
    .out_string_done  (out_string_done),
    .mismatches       (mismatches),
    .words_owed       (words_owed),
    .bytes_in         (bytes_in),
    .words_out        (words_out),
    .strings_seen     (strings_seen),
    .pairs_seen       (pairs_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Output side: random stall, or a long hold-off when asked for.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $error("timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("Verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_data_byte     <= b;
    in_end_of_string <= last;
    do @(posedge clk); while (in_stall);
    phase_sent++;
  endtask

  // Send unit_q low byte first; the end mark goes on the odd tail if present.
  task automatic send_units(input bit odd_tail, input logic [7:0] tail);
    foreach (unit_q[i]) begin
      send_byte(unit_q[i][7:0], 1'b0);
      send_byte(unit_q[i][15:8], !odd_tail && i == unit_q.size() - 1);
    end
    if (odd_tail)
      send_byte(tail, 1'b1);
    unit_q.delete();
  endtask

  task automatic send_random_string();
    int          count;
    int          pick;
    logic [15:0] u;
    count = $urandom_range(1, 6);
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        unit_q.insert(unit_q.size(), 16'($urandom_range(16'h7F)));
      end else if (pick < 50) begin
        unit_q.insert(unit_q.size(), 16'($urandom_range(16'h80, 16'h7FF)));
      end else if (pick < 65) begin
        u = 16'($urandom_range(16'h800, 16'hFFFF));
        if (u[15:11] == 5'b11011)
          u[14] = 1'b0;
        unit_q.insert(unit_q.size(), u);
      end else if (pick < 88) begin
        unit_q.insert(unit_q.size(), 16'($urandom_range(16'hD800, 16'hDBFF)));
        unit_q.insert(unit_q.size(), 16'($urandom_range(16'hDC00, 16'hDFFF)));
      end else begin
        // noise: lone or misordered surrogates land here too
        unit_q.insert(unit_q.size(), 16'($urandom_range(16'hFFFF)));
      end
    end
    send_units($urandom_range(9) == 0, 8'($urandom_range(255)));
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Boundaries of the one, two and three byte forms.
    unit_q = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hFFFF};
    send_units(1'b0, 8'h00);
    // Pairs at both ends, high before a plain unit, lone low, high at the end.
    unit_q = '{16'hDBFF, 16'hDFFF, 16'hD800, 16'hDC00, 16'hD812, 16'h0041,
               16'hDC00, 16'hDAFF};
    send_units(1'b0, 8'h00);
    // Held high surrogate flushed by an odd trailing byte.
    unit_q = '{16'hD801};
    send_units(1'b1, 8'h41);
    // Odd byte alone: only the empty end marker comes out.
    send_units(1'b1, 8'hFF);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  hold_request = 1'b1; end
        1: begin idle_pct = 78; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 78; end
        default: begin idle_pct = 20; stall_pct = 20; end
      endcase
      phase_sent = 0;
      while (phase_sent < PHASE_BYTES)
        send_random_string();
    end
    in_valid <= 1'b0;
    stall_pct = 20;

    @(negedge clk);
    while (words_owed != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d bytes in %0d strings (%0d surrogate pairs); checked %0d UTF-8 words.",
             bytes_in, strings_seen, pairs_seen, words_out);
    if (mismatches == 0 && words_owed == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/u16t_pkg.sv
rtl/u16t_front.sv
rtl/u16t_fifo.sv
rtl/u16t_back.sv
rtl/utf16le_to_utf8_transcoder.sv
rtl/u16t_checker.sv
tb/utf8_output_checker.sv
tb/tb_utf16le_to_utf8_transcoder.sv
